FILE: rtl/assert_macros.svh
// Assertion helpers shared by the controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/kmc_pkg.sv
`default_nettype none

package kmc_pkg;

    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_POLL  = 3'd2;
    localparam logic [2:0] REQ_KEY   = 3'd3;
    localparam logic [2:0] REQ_MOUSE = 3'd4;

    localparam logic [7:0] PORT_DATA   = 8'h60;
    localparam logic [7:0] PORT_B      = 8'h61;
    localparam logic [7:0] PORT_STATUS = 8'h64;

    localparam logic [7:0] CMD_ENQ_ZERO = 8'h05;
    localparam logic [7:0] CMD_LOAD_REL = 8'h11;
    localparam logic [7:0] CMD_LOAD_PKT = 8'h12;
    localparam logic [3:0] PARAMS_REL   = 4'd9;
    localparam logic [3:0] PARAMS_PKT   = 4'd4;

    localparam logic [7:0] STATUS_RESET = 8'h18;
    localparam logic [7:0] STATUS_FULL  = 8'h01;
    localparam logic [7:0] STATUS_CMD   = 8'h02;
    localparam logic [7:0] STATUS_ERR   = 8'h60;
    localparam logic [7:0] PACKET_HEAD  = 8'hfe;
    localparam logic [7:0] BREAK_BIT    = 8'h80;
    localparam logic [7:0] UNKNOWN_PORT = 8'hff;

    localparam int SCAN_ENTRIES = 7;
    localparam logic [7:0] SCAN_RESET [SCAN_ENTRIES] =
        '{8'h1c, 8'h53, 8'h01, 8'h4b, 8'h4d, 8'h48, 8'h50};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_DATA,
        OP_RD_PORTB,
        OP_RD_STATUS,
        OP_RD_OTHER,
        OP_WR_DATA,
        OP_WR_PORTB,
        OP_POLL,
        OP_KEY,
        OP_MOUSE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         data;
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic [2:0]         buttons;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/kmc_ram.sv
`default_nettype none

module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/kmc_front.sv
`default_nettype none

`include "assert_macros.svh"

module kmc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,
    input  wire logic [2:0]    s_tuser,
    output kmc_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_pop
);

    kmc_pkg::cmd_t fifo_reg [2];
    kmc_pkg::cmd_t cls;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic [7:0] port;

    assign port = s_tdata[7:0];

    always_comb
    begin
        cls.op      = kmc_pkg::OP_NONE;
        cls.data    = s_tdata[15:8];
        cls.dx      = s_tdata[33:24];
        cls.dy      = s_tdata[43:34];
        cls.buttons = s_tdata[46:44];
        unique case (s_tuser)
            kmc_pkg::REQ_READ:
            begin
                unique case (port)
                    kmc_pkg::PORT_DATA:   cls.op = kmc_pkg::OP_RD_DATA;
                    kmc_pkg::PORT_B:      cls.op = kmc_pkg::OP_RD_PORTB;
                    kmc_pkg::PORT_STATUS: cls.op = kmc_pkg::OP_RD_STATUS;
                    default:              cls.op = kmc_pkg::OP_RD_OTHER;
                endcase
            end
            kmc_pkg::REQ_WRITE:
            begin
                unique case (port)
                    kmc_pkg::PORT_DATA: cls.op = kmc_pkg::OP_WR_DATA;
                    kmc_pkg::PORT_B:    cls.op = kmc_pkg::OP_WR_PORTB;
                    default:            cls.op = kmc_pkg::OP_NONE;
                endcase
            end
            kmc_pkg::REQ_POLL:  cls.op = kmc_pkg::OP_POLL;
            kmc_pkg::REQ_KEY:
            begin
                cls.op   = kmc_pkg::OP_KEY;
                cls.data = s_tdata[23:16];
            end
            kmc_pkg::REQ_MOUSE: cls.op = kmc_pkg::OP_MOUSE;
            default:            cls.op = kmc_pkg::OP_NONE;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !(cmd_pop && cmd_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    `ASSERT_NEVER(a_pop_empty, cmd_pop && !cmd_valid, "request popped from empty queue")
    `ASSERT_CLK(a_count_ptrs, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg),
        "queue pointers disagree with count")

endmodule

`default_nettype wire

FILE: rtl/kmc_back.sv
`default_nettype none

`include "assert_macros.svh"

module kmc_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ACCUM_BITS  = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kmc_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AB = ACCUM_BITS;
    localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] LVL_FULL  = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] LVL_PKT   = PW'(QUEUE_DEPTH - 4);
    localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};
    localparam logic signed [AB-1:0] STEP_HI = AB'(4);
    localparam logic signed [AB-1:0] STEP_LO = AB'(-4);
    localparam logic signed [AB-1:0] LIM_HI  = AB'(127);
    localparam logic signed [AB-1:0] LIM_LO  = AB'(-127);
    localparam logic signed [AB:0]   NLIM_HI = (AB+1)'(127);
    localparam logic signed [AB:0]   NLIM_LO = (AB+1)'(-127);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_LOAD2,
        S_BTN,
        S_PKT_CHK,
        S_PKT_X,
        S_PKT_Y,
        S_STEP,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    kmc_pkg::cmd_t        cur_reg, cur_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [7:0]           status_reg, status_next;
    logic                 irq_wanted_reg, irq_wanted_next;
    logic [7:0]           command_reg, command_next;
    logic [3:0]           pidx_reg, pidx_next;
    logic [3:0]           pcnt_reg, pcnt_next;
    logic [7:0]           table_reg [kmc_pkg::SCAN_ENTRIES];
    logic [7:0]           table_next [kmc_pkg::SCAN_ENTRIES];
    logic                 packet_reg, packet_next;
    logic signed [AB-1:0] acc_x_reg, acc_x_next;
    logic signed [AB-1:0] acc_y_reg, acc_y_next;
    logic [2:0]           btn_reg, btn_next;
    logic [7:0]           portb_reg, portb_next;
    logic [1:0]           bidx_reg, bidx_next;
    logic [7:0]           px_reg, px_next;
    logic [7:0]           py_reg, py_next;
    logic [7:0]           rd_res_reg, rd_res_next;
    logic                 irq_res_reg, irq_res_next;
    logic                 inc_res_reg, inc_res_next;
    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_data_reg, m_data_next;

    logic [7:0]           pstore [kmc_pkg::SCAN_ENTRIES];
    logic                 pstore_we;
    logic [2:0]           pstore_idx;

    logic [PW:0]          diff;
    logic [PW-1:0]        level;
    logic [PW+3:0]        level_wide;
    logic                 full;
    logic                 push_en;
    logic [7:0]           push_byte;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    logic signed [AB:0]   sum_x, sum_y, neg_y;
    logic [3:0]           pidx_inc;
    logic [7:0]           code;

    always_comb
    begin
        diff = {1'b0, tail_reg} - {1'b0, head_reg};
        if (tail_reg < head_reg)
        begin
            diff = diff + (PW+1)'(QUEUE_DEPTH);
        end
        level      = diff[PW-1:0];
        level_wide = (PW+4)'(level);
        full       = (level == LVL_FULL);
    end

    assign ram_we = push_en && !full;

    kmc_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (push_byte),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign sum_x    = {acc_x_reg[AB-1], acc_x_reg} + {{(AB-9){cur_reg.dx[9]}}, cur_reg.dx};
    assign sum_y    = {acc_y_reg[AB-1], acc_y_reg} + {{(AB-9){cur_reg.dy[9]}}, cur_reg.dy};
    assign neg_y    = -{acc_y_reg[AB-1], acc_y_reg};
    assign pidx_inc = pidx_reg + 4'd1;

    always_comb
    begin
        unique case (bidx_reg)
            2'd0:    code = table_reg[0];
            2'd1:    code = table_reg[2];
            2'd2:    code = table_reg[1];
            default: code = table_reg[0];
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_byte_next   = out_byte_reg;
        status_next     = status_reg;
        irq_wanted_next = irq_wanted_reg;
        command_next    = command_reg;
        pidx_next       = pidx_reg;
        pcnt_next       = pcnt_reg;
        table_next      = table_reg;
        packet_next     = packet_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        btn_next        = btn_reg;
        portb_next      = portb_reg;
        bidx_next       = bidx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        rd_res_next     = rd_res_reg;
        irq_res_next    = irq_res_reg;
        inc_res_next    = inc_res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        cmd_pop         = 1'b0;
        push_en         = 1'b0;
        push_byte       = 8'h00;
        pstore_we       = 1'b0;
        pstore_idx      = pidx_reg[2:0];

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next     = cmd;
                    cmd_pop      = 1'b1;
                    rd_res_next  = 8'h00;
                    irq_res_next = 1'b0;
                    inc_res_next = 1'b0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cur_reg.op)
                    kmc_pkg::OP_RD_DATA:
                    begin
                        rd_res_next = out_byte_reg;
                        if (level == '0)
                        begin
                            status_next     = status_reg & ~kmc_pkg::STATUS_FULL;
                            irq_wanted_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    kmc_pkg::OP_RD_PORTB:
                    begin
                        rd_res_next = portb_reg;
                    end
                    kmc_pkg::OP_RD_STATUS:
                    begin
                        rd_res_next = status_reg;
                        status_next = status_reg & ~kmc_pkg::STATUS_ERR;
                    end
                    kmc_pkg::OP_RD_OTHER:
                    begin
                        rd_res_next = kmc_pkg::UNKNOWN_PORT;
                    end
                    kmc_pkg::OP_WR_PORTB:
                    begin
                        portb_next = cur_reg.data;
                    end
                    kmc_pkg::OP_WR_DATA:
                    begin
                        if (pidx_reg != pcnt_reg)
                        begin
                            pstore_we = (pidx_reg < 4'(kmc_pkg::SCAN_ENTRIES));
                            pidx_next = pidx_inc;
                            if (pidx_inc == pcnt_reg)
                            begin
                                if (command_reg == kmc_pkg::CMD_LOAD_REL)
                                begin
                                    packet_next = 1'b0;
                                    table_next  = pstore;
                                end
                                else if (command_reg == kmc_pkg::CMD_LOAD_PKT)
                                begin
                                    packet_next   = 1'b1;
                                    table_next[0] = pstore[0];
                                    table_next[1] = pstore[1];
                                    table_next[2] = pstore[2];
                                end
                            end
                        end
                        else
                        begin
                            command_next = cur_reg.data;
                            unique case (cur_reg.data)
                                kmc_pkg::CMD_ENQ_ZERO:
                                begin
                                    push_en   = 1'b1;
                                    push_byte = 8'h00;
                                end
                                kmc_pkg::CMD_LOAD_REL:
                                begin
                                    pidx_next = 4'd0;
                                    pcnt_next = kmc_pkg::PARAMS_REL;
                                end
                                kmc_pkg::CMD_LOAD_PKT:
                                begin
                                    pidx_next = 4'd0;
                                    pcnt_next = kmc_pkg::PARAMS_PKT;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    kmc_pkg::OP_POLL:
                    begin
                        irq_res_next    = irq_wanted_reg;
                        irq_wanted_next = 1'b0;
                        if (!status_reg[0] && level != '0)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    kmc_pkg::OP_KEY:
                    begin
                        push_en   = 1'b1;
                        push_byte = cur_reg.data;
                    end
                    kmc_pkg::OP_MOUSE:
                    begin
                        if (sum_x[AB] != sum_x[AB-1])
                        begin
                            acc_x_next = sum_x[AB] ? ACC_MIN : ACC_MAX;
                        end
                        else
                        begin
                            acc_x_next = sum_x[AB-1:0];
                        end
                        if (sum_y[AB] != sum_y[AB-1])
                        begin
                            acc_y_next = sum_y[AB] ? ACC_MIN : ACC_MAX;
                        end
                        else
                        begin
                            acc_y_next = sum_y[AB-1:0];
                        end
                        bidx_next  = 2'd0;
                        state_next = S_BTN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LOAD:
            begin
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                out_byte_next   = ram_rdata;
                head_next       = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                status_next     = (status_reg | kmc_pkg::STATUS_FULL) & ~kmc_pkg::STATUS_CMD;
                irq_wanted_next = 1'b1;
                state_next      = S_DONE;
            end
            S_BTN:
            begin
                if (full)
                begin
                    inc_res_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    if (cur_reg.buttons[bidx_reg] && !btn_reg[bidx_reg])
                    begin
                        push_en   = 1'b1;
                        push_byte = code;
                    end
                    else if (!cur_reg.buttons[bidx_reg] && btn_reg[bidx_reg])
                    begin
                        push_en   = 1'b1;
                        push_byte = code | kmc_pkg::BREAK_BIT;
                    end
                    btn_next[bidx_reg] = cur_reg.buttons[bidx_reg];
                    bidx_next = bidx_reg + 2'd1;
                    if (bidx_reg == 2'd2)
                    begin
                        state_next = packet_reg ? S_PKT_CHK : S_STEP;
                    end
                end
            end
            S_PKT_CHK:
            begin
                if (level > LVL_PKT)
                begin
                    inc_res_next = 1'b1;
                    state_next   = S_DONE;
                end
                else if (acc_x_reg == '0 && acc_y_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    push_en   = 1'b1;
                    push_byte = kmc_pkg::PACKET_HEAD;
                    if (acc_x_reg < LIM_LO)
                    begin
                        px_next = LIM_LO[7:0];
                    end
                    else if (acc_x_reg > LIM_HI)
                    begin
                        px_next = LIM_HI[7:0];
                    end
                    else
                    begin
                        px_next = acc_x_reg[7:0];
                    end
                    if (neg_y < NLIM_LO)
                    begin
                        py_next = NLIM_LO[7:0];
                    end
                    else if (neg_y > NLIM_HI)
                    begin
                        py_next = NLIM_HI[7:0];
                    end
                    else
                    begin
                        py_next = neg_y[7:0];
                    end
                    state_next = S_PKT_X;
                end
            end
            S_PKT_X:
            begin
                push_en    = 1'b1;
                push_byte  = px_reg;
                state_next = S_PKT_Y;
            end
            S_PKT_Y:
            begin
                push_en    = 1'b1;
                push_byte  = py_reg;
                acc_x_next = '0;
                acc_y_next = '0;
                state_next = S_DONE;
            end
            S_STEP:
            begin
                if (acc_x_reg < STEP_LO || acc_x_reg > STEP_HI ||
                    acc_y_reg < STEP_LO || acc_y_reg > STEP_HI)
                begin
                    if (full)
                    begin
                        inc_res_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (acc_x_reg < STEP_LO)
                    begin
                        acc_x_next = acc_x_reg + STEP_HI;
                        push_en    = 1'b1;
                        push_byte  = table_reg[3];
                    end
                    else if (acc_x_reg > STEP_HI)
                    begin
                        acc_x_next = acc_x_reg - STEP_HI;
                        push_en    = 1'b1;
                        push_byte  = table_reg[4];
                    end
                    else if (acc_y_reg < STEP_LO)
                    begin
                        acc_y_next = acc_y_reg + STEP_HI;
                        push_en    = 1'b1;
                        push_byte  = table_reg[5];
                    end
                    else
                    begin
                        acc_y_next = acc_y_reg - STEP_HI;
                        push_en    = 1'b1;
                        push_byte  = table_reg[6];
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {level_wide[3:0], inc_res_reg, portb_reg[1],
                                    portb_reg[0], irq_res_reg, rd_res_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_byte_reg   <= 8'h00;
            status_reg     <= kmc_pkg::STATUS_RESET;
            irq_wanted_reg <= 1'b0;
            command_reg    <= 8'h00;
            pidx_reg       <= 4'd0;
            pcnt_reg       <= 4'd0;
            table_reg      <= kmc_pkg::SCAN_RESET;
            packet_reg     <= 1'b0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            btn_reg        <= 3'd0;
            portb_reg      <= 8'h00;
            bidx_reg       <= 2'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_byte_reg   <= out_byte_next;
            status_reg     <= status_next;
            irq_wanted_reg <= irq_wanted_next;
            command_reg    <= command_next;
            pidx_reg       <= pidx_next;
            pcnt_reg       <= pcnt_next;
            table_reg      <= table_next;
            packet_reg     <= packet_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            btn_reg        <= btn_next;
            portb_reg      <= portb_next;
            bidx_reg       <= bidx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        rd_res_reg  <= rd_res_next;
        irq_res_reg <= irq_res_next;
        inc_res_reg <= inc_res_next;
        m_data_reg  <= m_data_next;
        if (pstore_we)
        begin
            pstore[pstore_idx] <= cur_reg.data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_NEVER(a_push_full, ram_we && full, "write into a full scancode queue")
    `ASSERT_CLK(a_load_seq, (state_reg == S_LOAD2) |-> $past(state_reg == S_LOAD),
        "queue read data used without a read cycle")
    `ASSERT_CLK(a_pop_idle, cmd_pop |-> (state_reg == S_IDLE),
        "request taken while another is in progress")

endmodule

`default_nettype wire

FILE: rtl/keyboard_mouse_controller.sv
// Keyboard and mouse controller with a scancode queue.
// Input channel s_*: one request per handshake; s_tuser carries the request
// kind (bus read, bus write, poll tick, key byte, mouse event), s_tdata the
// port, write byte, key byte, mouse motion and buttons.
// Output channel m_*: exactly one result per request, in request order.
// A two-entry request queue sits ahead of the execution sequencer, so new
// requests are taken while a result waits on m_tready.
// Each request is taken from the queue into S_EXEC and its result is
// registered through S_DONE; moving a byte from the scancode queue into
// the output byte adds a read of the queue memory (S_LOAD, S_LOAD2). Mouse
// events walk the buttons (S_BTN), then push step codes (S_STEP) or send a
// packet (S_PKT_CHK, S_PKT_X, S_PKT_Y); the sequencer pushes at most one byte
// a cycle into the scancode memory. One request is executed at a time.
// A stalled receiver holds the result in the output register; the sequencer
// then waits and the request queue fills, dropping s_tready.
// Reset clears the queue pointers, status (to 0x18), accumulators, buttons
// and scan table (to its default codes); queue memory needs no clearing.
`default_nettype none

module keyboard_mouse_controller #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ACCUM_BITS  = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // port, write_data, key_byte, mouse_dx, mouse_dy, mouse_buttons, pad
    input  wire logic [47:0] s_tdata,
    // req_type
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, irq_pulse, speaker_gate, speaker_on, mouse_incomplete,
    // queue_level
    output logic [15:0]      m_tdata
);

    kmc_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    kmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    kmc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ACCUM_BITS  (ACCUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: test/keyboard_mouse_controller_tb.sv
`default_nettype none

module keyboard_mouse_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = 16;
    localparam int ABITS = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        port;
        logic [7:0]        wdata;
        logic [7:0]        key;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
        logic [2:0]        buttons;
    } kmc_req_t;

    localparam int REQ_BITS = $bits(kmc_req_t);

    typedef struct packed {
        logic [3:0] level;
        logic       incomplete;
        logic       enable;
        logic       gate;
        logic       irq;
        logic [7:0] rdata;
    } kmc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    kmc_req_t pending_reqs[$];
    kmc_rsp_t expected_rsps[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       calm;
    int       holdoff;

    // predictor state
    logic [7:0]  p_queue [QDEPTH];
    int          p_head;
    int          p_tail;
    logic [7:0]  p_out;
    logic [7:0]  p_status;
    bit          p_irq;
    logic [7:0]  p_cmd;
    int          p_pidx;
    int          p_pcnt;
    logic [7:0]  p_params [16];
    logic [7:0]  p_scan [kmc_pkg::SCAN_ENTRIES];
    bit          p_packet;
    longint      p_ax;
    longint      p_ay;
    logic [2:0]  p_buttons;
    logic [7:0]  p_portb;

    keyboard_mouse_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int queue_fill();
        return (p_tail + QDEPTH - p_head) % QDEPTH;
    endfunction

    task automatic push_code(input logic [7:0] v);
        if (queue_fill() < QDEPTH - 1)
        begin
            p_queue[p_tail] = v;
            p_tail = (p_tail + 1) % QDEPTH;
        end
    endtask

    task automatic pop_to_output();
        p_out = p_queue[p_head];
        p_head = (p_head + 1) % QDEPTH;
        p_status = (p_status | kmc_pkg::STATUS_FULL) & ~kmc_pkg::STATUS_CMD;
        p_irq = 1'b1;
    endtask

    function automatic longint sat_accum(input longint a, input longint d);
        longint hi;
        longint s;
        hi = (longint'(1) << (ABITS - 1)) - 1;
        s = a + d;
        if (s > hi)
            s = hi;
        if (s < -hi - 1)
            s = -hi - 1;
        return s;
    endfunction

    function automatic longint clip127(input longint v);
        if (v < -127)
            return -127;
        if (v > 127)
            return 127;
        return v;
    endfunction

    task automatic mouse_move(input kmc_req_t r, output bit stopped);
        int         slot [3];
        logic [2:0] m;
        longint     px;
        longint     py;
        slot = '{0, 2, 1};
        stopped = 1'b0;
        p_ax = sat_accum(p_ax, longint'(r.dx));
        p_ay = sat_accum(p_ay, longint'(r.dy));
        for (int i = 0; i < 3; i++)
        begin
            m = 3'b1 << i;
            if (queue_fill() > QDEPTH - 2)
            begin
                stopped = 1'b1;
                return;
            end
            if ((r.buttons & m) != 0 && (p_buttons & m) == 0)
                push_code(p_scan[slot[i]]);
            if ((r.buttons & m) == 0 && (p_buttons & m) != 0)
                push_code(p_scan[slot[i]] | kmc_pkg::BREAK_BIT);
            p_buttons = (p_buttons & ~m) | (r.buttons & m);
        end
        if (p_packet)
        begin
            if (queue_fill() > QDEPTH - 4)
            begin
                stopped = 1'b1;
                return;
            end
            if (p_ax == 0 && p_ay == 0)
                return;
            px = clip127(p_ax);
            py = clip127(-p_ay);
            push_code(kmc_pkg::PACKET_HEAD);
            push_code(px[7:0]);
            push_code(py[7:0]);
            p_ax = 0;
            p_ay = 0;
            return;
        end
        while (p_ax < -4)
        begin
            if (queue_fill() > QDEPTH - 2)
            begin
                stopped = 1'b1;
                return;
            end
            p_ax += 4;
            push_code(p_scan[3]);
        end
        while (p_ax > 4)
        begin
            if (queue_fill() > QDEPTH - 2)
            begin
                stopped = 1'b1;
                return;
            end
            p_ax -= 4;
            push_code(p_scan[4]);
        end
        while (p_ay < -4)
        begin
            if (queue_fill() > QDEPTH - 2)
            begin
                stopped = 1'b1;
                return;
            end
            p_ay += 4;
            push_code(p_scan[5]);
        end
        while (p_ay > 4)
        begin
            if (queue_fill() > QDEPTH - 2)
            begin
                stopped = 1'b1;
                return;
            end
            p_ay -= 4;
            push_code(p_scan[6]);
        end
    endtask

    task automatic data_port_write(input logic [7:0] v);
        if (p_pidx != p_pcnt)
        begin
            p_params[p_pidx & 15] = v;
            p_pidx = (p_pidx + 1) & 15;
            if (p_pidx == p_pcnt)
            begin
                if (p_cmd == kmc_pkg::CMD_LOAD_REL)
                begin
                    p_packet = 1'b0;
                    for (int i = 0; i < kmc_pkg::SCAN_ENTRIES; i++)
                        p_scan[i] = p_params[i];
                end
                else if (p_cmd == kmc_pkg::CMD_LOAD_PKT)
                begin
                    p_packet = 1'b1;
                    for (int i = 0; i < 3; i++)
                        p_scan[i] = p_params[i];
                end
            end
            return;
        end
        p_cmd = v;
        if (v == kmc_pkg::CMD_ENQ_ZERO)
            push_code(8'h00);
        else if (v == kmc_pkg::CMD_LOAD_REL)
        begin
            p_pidx = 0;
            p_pcnt = int'(kmc_pkg::PARAMS_REL);
        end
        else if (v == kmc_pkg::CMD_LOAD_PKT)
        begin
            p_pidx = 0;
            p_pcnt = int'(kmc_pkg::PARAMS_PKT);
        end
    endtask

    task automatic predict_response(input kmc_req_t r);
        kmc_rsp_t e;
        bit       stopped;
        e = '0;
        case (r.kind)
            kmc_pkg::REQ_READ:
            begin
                e.rdata = kmc_pkg::UNKNOWN_PORT;
                if (r.port == kmc_pkg::PORT_DATA)
                begin
                    e.rdata = p_out;
                    if (queue_fill() == 0)
                    begin
                        p_status = p_status & ~kmc_pkg::STATUS_FULL;
                        p_irq = 1'b0;
                    end
                    else
                        pop_to_output();
                end
                else if (r.port == kmc_pkg::PORT_B)
                    e.rdata = p_portb;
                else if (r.port == kmc_pkg::PORT_STATUS)
                begin
                    e.rdata = p_status;
                    p_status = p_status & ~kmc_pkg::STATUS_ERR;
                end
            end
            kmc_pkg::REQ_WRITE:
            begin
                if (r.port == kmc_pkg::PORT_DATA)
                    data_port_write(r.wdata);
                else if (r.port == kmc_pkg::PORT_B)
                    p_portb = r.wdata;
            end
            kmc_pkg::REQ_POLL:
            begin
                if (p_irq)
                begin
                    p_irq = 1'b0;
                    e.irq = 1'b1;
                end
                if ((p_status & kmc_pkg::STATUS_FULL) == 0 && queue_fill() != 0)
                    pop_to_output();
            end
            kmc_pkg::REQ_KEY:
                push_code(r.key);
            kmc_pkg::REQ_MOUSE:
            begin
                mouse_move(r, stopped);
                e.incomplete = stopped;
            end
            default:
            begin
            end
        endcase
        e.gate = p_portb[0];
        e.enable = p_portb[1];
        e.level = 4'(queue_fill());
        expected_rsps.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    task automatic add_req(input logic [2:0] kind, input logic [7:0] port,
                           input logic [7:0] wdata, input logic [7:0] key,
                           input int dx, input int dy, input logic [2:0] buttons);
        kmc_req_t r;
        r.kind = kind;
        r.port = port;
        r.wdata = wdata;
        r.key = key;
        r.dx = dx[9:0];
        r.dy = dy[9:0];
        r.buttons = buttons;
        pending_reqs.push_back(r);
    endtask

    task automatic add_random_req();
        kmc_req_t r;
        int       pick;
        r = kmc_req_t'(REQ_BITS'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            r.kind = kmc_pkg::REQ_READ;
            r.port = ($urandom_range(0, 4) != 0) ?
                (($urandom_range(0, 2) != 0) ? kmc_pkg::PORT_DATA : kmc_pkg::PORT_STATUS) :
                r.port;
        end
        else if (pick < 32)
        begin
            r.kind = kmc_pkg::REQ_WRITE;
            if ($urandom_range(0, 3) != 0)
                r.port = ($urandom_range(0, 1) != 0) ? kmc_pkg::PORT_DATA : kmc_pkg::PORT_B;
        end
        else if (pick < 55)
            r.kind = kmc_pkg::REQ_POLL;
        else if (pick < 72)
            r.kind = kmc_pkg::REQ_KEY;
        else if (pick < 95)
        begin
            r.kind = kmc_pkg::REQ_MOUSE;
            if ($urandom_range(0, 2) != 0)
            begin
                r.dx = 10'(int'($urandom_range(0, 60)) - 30);
                r.dy = 10'(int'($urandom_range(0, 60)) - 30);
            end
        end
        else
            r.kind = 3'($urandom_range(5, 7));
        pending_reqs.push_back(r);
    endtask

    task automatic add_table_load(input bit packet);
        int n;
        n = packet ? int'(kmc_pkg::PARAMS_PKT) : int'(kmc_pkg::PARAMS_REL);
        add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_DATA,
                packet ? kmc_pkg::CMD_LOAD_PKT : kmc_pkg::CMD_LOAD_REL, 0, 0, 0, 0);
        for (int i = 0; i < n; i++)
            add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_DATA, 8'($urandom), 0, 0, 0, 0);
    endtask

    initial
    begin
        p_head = 0;
        p_tail = 0;
        p_out = '0;
        p_status = kmc_pkg::STATUS_RESET;
        p_irq = 1'b0;
        p_cmd = '0;
        p_pidx = 0;
        p_pcnt = 0;
        p_packet = 1'b0;
        p_ax = 0;
        p_ay = 0;
        p_buttons = '0;
        p_portb = '0;
        for (int i = 0; i < kmc_pkg::SCAN_ENTRIES; i++)
            p_scan[i] = kmc_pkg::SCAN_RESET[i];
        for (int i = 0; i < QDEPTH; i++)
            p_queue[i] = '0;
        for (int i = 0; i < 16; i++)
            p_params[i] = '0;

        add_req(kmc_pkg::REQ_READ, kmc_pkg::PORT_STATUS, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_READ, kmc_pkg::PORT_DATA, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_READ, 8'h00, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_B, 8'hff, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_READ, kmc_pkg::PORT_B, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_STATUS, 8'h55, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_DATA, kmc_pkg::CMD_ENQ_ZERO, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_WRITE, kmc_pkg::PORT_DATA, 8'h33, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_POLL, 0, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_POLL, 0, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_READ, kmc_pkg::PORT_DATA, 0, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            add_req(kmc_pkg::REQ_KEY, 0, 0, 8'(i * 17), 0, 0, 0);
        add_req(kmc_pkg::REQ_MOUSE, 0, 0, 0, 511, -512, 3'b111);
        add_req(kmc_pkg::REQ_READ, kmc_pkg::PORT_DATA, 0, 0, 0, 0, 0);
        add_req(kmc_pkg::REQ_MOUSE, 0, 0, 0, -512, 511, 3'b000);
        add_req(3'd7, 0, 0, 0, 0, 0, 0);
        add_table_load(1'b1);
        add_req(kmc_pkg::REQ_MOUSE, 0, 0, 0, 0, 0, 3'b000);
        add_req(kmc_pkg::REQ_MOUSE, 0, 0, 0, -300, 300, 3'b101);
        add_table_load(1'b0);

        for (int i = 0; i < 400; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                add_table_load(1'($urandom_range(0, 1)));
            else
                add_random_req();
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 27))
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_reqs[0].kind;
                s_tdata <= {1'b0, pending_reqs[0].buttons, pending_reqs[0].dy,
                            pending_reqs[0].dx, pending_reqs[0].key,
                            pending_reqs[0].wdata, pending_reqs[0].port};
                predict_response(pending_reqs[0]);
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (pending_reqs.size() == 0)
                    stim_done <= 1'b1;
            end
        end
    end

    // receiver pacing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            holdoff <= 0;
            calm <= 1'b0;
        end
        else
        begin
            if (pending_reqs.size() < 300 && pending_reqs.size() > 200)
                calm <= 1'b1;
            else
                calm <= 1'b0;
            if (holdoff > 0)
            begin
                holdoff <= holdoff - 1;
                m_tready <= 1'b0;
            end
            else if (pending_reqs.size() == 350 && s_tvalid && s_tready)
            begin
                holdoff <= 300;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 27);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        kmc_rsp_t got;
        kmc_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected response %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.irq !== want.irq)
                    report_mismatch("irq_pulse", got.irq, want.irq);
                if (got.gate !== want.gate)
                    report_mismatch("speaker_gate", got.gate, want.gate);
                if (got.enable !== want.enable)
                    report_mismatch("speaker_on", got.enable, want.enable);
                if (got.incomplete !== want.incomplete)
                    report_mismatch("mouse_incomplete", got.incomplete, want.incomplete);
                if (got.level !== want.level)
                    report_mismatch("queue_level", got.level, want.level);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_rsps.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
